### hw/rtl/c2rd_pkg.sv
// shared constants, types and table functions for the ra/dec converter
`default_nettype none
package c2rd_pkg;

  localparam int POS_WIDTH    = 40;
  localparam int ANGLE_WIDTH  = 32;
  localparam int DIFF_WIDTH   = POS_WIDTH + 1;
  localparam int MSB_W        = $clog2(DIFF_WIDTH);
  localparam int CORDIC_STEPS = 60;
  localparam int NORM_TOP     = 59;

  localparam logic [63:0] QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_TURN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TWO_PI_INV   = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0] GAIN_SEED    = 64'h9B74_EDA8_0000_0000;
  localparam logic [63:0] THREE_Q62    = 64'hC000_0000_0000_0000;
  localparam logic [63:0] ROUND_BIT    = 64'h1 << (63 - ANGLE_WIDTH);

  // sideband that rides along a cordic pipe
  typedef struct packed {
    logic [2:0]  flags;
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] w;
  } side_t;

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) as a fraction of a turn, 2^64 per turn
  function automatic logic [63:0] ang_entry(input int i);
    logic [63:0] s;
    logic [63:0] term;
    s = '0;
    if (i == 0) begin
      s = 64'h1 << 61;
    end else begin
      for (int k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) < 64) begin
          term = udiv64(TWO_PI_INV >> (i * (2 * k + 1)), 64'(2 * k + 1));
          if ((k & 1) != 0) s = s - term;
          else s = s + term;
        end
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[127:64];
  endfunction

  function automatic logic [63:0] inv_gain_calc();
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] t;
    p = 64'h1 << 62;
    g = GAIN_SEED;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int n = 0; n < 5; n++) begin
      t = mul_hi(p, mul_hi(g, g));
      g = mul_hi(g, THREE_Q62 - t) << 1;
    end
    return g;
  endfunction

  localparam logic [63:0] INV_GAIN = inv_gain_calc();

endpackage
`default_nettype wire

### hw/rtl/c2rd_front.sv
// differences, magnitudes and common normalization of the line-of-sight vector
`default_nettype none
module c2rd_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_v,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] obj_x,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] obj_y,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] obj_z,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] station_x,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] station_y,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0] station_z,
  output logic                                       out_v,
  output c2rd_pkg::side_t                            out_side
);
  import c2rd_pkg::*;

  logic signed [DIFF_WIDTH-1:0] dx, dy, dz;
  logic v1, v2;
  logic [DIFF_WIDTH-1:0] ax1, ay1, az1, ax2, ay2, az2;
  logic [2:0] sg1, sg2;
  logic [DIFF_WIDTH-1:0] mor;
  logic [MSB_W-1:0] msb_next, msb;
  logic [63:0] wx, wy, wz;
  logic [6:0] lsh, rsh;

  assign dx = DIFF_WIDTH'(obj_x) - DIFF_WIDTH'(station_x);
  assign dy = DIFF_WIDTH'(obj_y) - DIFF_WIDTH'(station_y);
  assign dz = DIFF_WIDTH'(obj_z) - DIFF_WIDTH'(station_z);

  // msb of the or equals msb of the largest magnitude
  always_comb begin
    mor      = ax1 | ay1 | az1;
    msb_next = '0;
    for (int b = 0; b < DIFF_WIDTH; b++) begin
      if (mor[b]) msb_next = MSB_W'(b);
    end
  end

  always_comb begin
    lsh = 7'(NORM_TOP) - 7'(msb);
    rsh = 7'(msb) - 7'(NORM_TOP);
    if (7'(msb) <= 7'(NORM_TOP)) begin
      wx = 64'(ax2) << lsh;
      wy = 64'(ay2) << lsh;
      wz = 64'(az2) << lsh;
    end else begin
      wx = 64'(ax2) >> rsh;
      wy = 64'(ay2) >> rsh;
      wz = 64'(az2) >> rsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
    if (en) begin
      sg1 <= {dx[DIFF_WIDTH-1], dy[DIFF_WIDTH-1], dz[DIFF_WIDTH-1]};
      ax1 <= dx[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx) : DIFF_WIDTH'(dx);
      ay1 <= dy[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy) : DIFF_WIDTH'(dy);
      az1 <= dz[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dz) : DIFF_WIDTH'(dz);
      sg2 <= sg1;
      ax2 <= ax1;
      ay2 <= ay1;
      az2 <= az1;
      msb <= msb_next;
      out_side.flags <= sg2;
      out_side.u     <= wx;
      out_side.v     <= wy;
      out_side.w     <= wz;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/c2rd_cordic.sv
// unrolled vectoring cordic, one micro-rotation per register stage
`default_nettype none
module c2rd_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic signed [63:0] x_in,
  input  wire logic signed [63:0] y_in,
  input  wire c2rd_pkg::side_t    side_in,
  output logic                    out_v,
  output logic signed [63:0]      x_out,
  output logic [63:0]             z_out,
  output c2rd_pkg::side_t         side_out
);
  import c2rd_pkg::*;

  logic               va [1:CORDIC_STEPS];
  logic signed [63:0] xa [1:CORDIC_STEPS];
  logic signed [63:0] ya [1:CORDIC_STEPS];
  logic [63:0]        za [1:CORDIC_STEPS];
  side_t              sa [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic [63:0] ANG = ang_entry(i);
    logic               cv;
    logic signed [63:0] cx, cy;
    logic [63:0]        cz;
    side_t              cs;
    if (i == 0) begin : g_first
      assign cv = in_v;
      assign cx = x_in;
      assign cy = y_in;
      assign cz = '0;
      assign cs = side_in;
    end else begin : g_rest
      assign cv = va[i];
      assign cx = xa[i];
      assign cy = ya[i];
      assign cz = za[i];
      assign cs = sa[i];
    end
    always_ff @(posedge clk) begin
      if (rst) va[i+1] <= 1'b0;
      else if (en) va[i+1] <= cv;
      if (en) begin
        sa[i+1] <= cs;
        if (!cy[63]) begin
          xa[i+1] <= cx + (cy >>> i);
          ya[i+1] <= cy - (cx >>> i);
          za[i+1] <= cz + ANG;
        end else begin
          xa[i+1] <= cx - (cy >>> i);
          ya[i+1] <= cy + (cx >>> i);
          za[i+1] <= cz - ANG;
        end
      end
    end
  end

  assign out_v    = va[CORDIC_STEPS];
  assign x_out    = xa[CORDIC_STEPS];
  assign z_out    = za[CORDIC_STEPS];
  assign side_out = sa[CORDIC_STEPS];

endmodule
`default_nettype wire

### hw/rtl/c2rd_gain.sv
// quadrant fold of the azimuth and gain correction of the horizontal radius
`default_nettype none
module c2rd_gain (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic signed [63:0] mag,
  input  wire logic [63:0]        z_in,
  input  wire c2rd_pkg::side_t    side_in,
  output logic                    out_v,
  output logic signed [63:0]      r_out,
  output c2rd_pkg::side_t         side_out
);
  import c2rd_pkg::*;

  logic [63:0] zsel, turn;
  logic hz, axis, nx, ny, nz;
  logic v1, v2, v3;
  side_t s1, s2, s3;
  logic [31:0] ahi1, ahi2, ahi3, alo1, alo2;
  logic [63:0] pp1;
  logic [64:0] acc2;
  logic [65:0] acc3;
  logic [63:0] r_mul;

  assign nx = side_in.flags[2];
  assign ny = side_in.flags[1];
  assign nz = side_in.flags[0];
  assign hz = (side_in.u == '0) && (side_in.v == '0);
  assign axis = (side_in.u == '0) || (side_in.v == '0);

  always_comb begin
    if (side_in.v == '0) zsel = '0;
    else if (side_in.u == '0) zsel = QUARTER_TURN;
    else zsel = z_in;
    if (hz) turn = '0;
    else if (!nx && !ny) turn = zsel;
    else if (nx && !ny) turn = HALF_TURN - zsel;
    else if (nx && ny) turn = HALF_TURN + zsel;
    else turn = 64'd0 - zsel;
  end

  assign r_mul = acc3[65:32] + 64'(ahi3) * 64'(INV_GAIN[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      v3    <= v2;
      out_v <= v3;
    end
    if (en) begin
      // radius is the other magnitude when one axis is empty
      s1.flags <= {hz, axis, nz};
      s1.u     <= turn;
      s1.v     <= (side_in.v == '0) ? side_in.u : side_in.v;
      s1.w     <= side_in.w;
      pp1      <= 64'(mag[31:0]) * 64'(INV_GAIN[31:0]);
      ahi1     <= mag[63:32];
      alo1     <= mag[31:0];
      s2       <= s1;
      ahi2     <= ahi1;
      alo2     <= alo1;
      acc2     <= 65'(pp1[63:32]) + 65'(64'(ahi1) * 64'(INV_GAIN[31:0]));
      s3       <= s2;
      ahi3     <= ahi2;
      acc3     <= 66'(acc2) + 66'(64'(alo2) * 64'(INV_GAIN[63:32]));
      side_out <= s3;
      if (s3.flags[2]) r_out <= '0;
      else if (s3.flags[1]) r_out <= s3.v;
      else r_out <= r_mul;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cartesian_to_ra_dec_unit.sv
// top level of the cartesian to right ascension / declination converter
//
// input channel: in_valid/in_stall carry one word of object and station
// coordinates; a word is taken at a clock edge with in_valid high and
// in_stall low. output channel: out_valid/out_stall carry ra and dec.
// the pipe has 3 front-end stages, 60 azimuth cordic stages, 4 gain
// multiply stages, 60 elevation cordic stages and the output register.
// while the output is not stalled, one word enters every cycle and
// throughput is one result per cycle, set by the fully unrolled cordic pipes.
// when the receiver stalls with a result waiting, the whole pipe holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// synchronous reset clears all valid bits; payload registers are not reset.
// a zero vector gives ra = 0 and dec = 0.
`default_nettype none
module cartesian_to_ra_dec_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   obj_x,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   obj_y,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   obj_z,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   station_x,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   station_y,
  input  wire logic signed [c2rd_pkg::POS_WIDTH-1:0]   station_z,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [c2rd_pkg::ANGLE_WIDTH-1:0]             ra,
  output logic signed [c2rd_pkg::ANGLE_WIDTH-1:0]      dec
);
  import c2rd_pkg::*;

  logic en;
  logic f_v, c1_v, g_v, c2_v;
  side_t f_side, c1_side, g_side, c2_side;
  logic signed [63:0] c1_x, g_r;
  logic [63:0] c1_z, c2_z;
  logic [63:0] w, wr, tr;
  logic [ANGLE_WIDTH-1:0] wq;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  c2rd_front u_front (
    .clk, .rst, .en, .in_v(in_valid),
    .obj_x, .obj_y, .obj_z, .station_x, .station_y, .station_z,
    .out_v(f_v), .out_side(f_side)
  );

  c2rd_cordic u_azim (
    .clk, .rst, .en, .in_v(f_v),
    .x_in(f_side.u), .y_in(f_side.v), .side_in(f_side),
    .out_v(c1_v), .x_out(c1_x), .z_out(c1_z), .side_out(c1_side)
  );

  c2rd_gain u_gain (
    .clk, .rst, .en, .in_v(c1_v), .mag(c1_x), .z_in(c1_z), .side_in(c1_side),
    .out_v(g_v), .r_out(g_r), .side_out(g_side)
  );

  c2rd_cordic u_elev (
    .clk, .rst, .en, .in_v(g_v),
    .x_in(g_r), .y_in(g_side.w), .side_in(g_side),
    .out_v(c2_v), .x_out(), .z_out(c2_z), .side_out(c2_side)
  );

  // elevation special cases, clamp to [0, quarter turn], round half up
  always_comb begin
    if (c2_side.w == '0) w = '0;
    else if (c2_side.flags[2]) w = QUARTER_TURN;
    else w = c2_z;
    if (w[63]) w = '0;
    if (w > QUARTER_TURN) w = QUARTER_TURN;
    wr = w + ROUND_BIT;
    tr = c2_side.u + ROUND_BIT;
    wq = wr[63 -: ANGLE_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= c2_v;
    if (en) begin
      ra  <= tr[63 -: ANGLE_WIDTH];
      dec <= c2_side.flags[0] ? ANGLE_WIDTH'(-wq) : wq;
    end
  end

  a_stall_rule: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  a_dec_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(dec) <= $signed(ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2)))
      && ($signed(dec) >= -$signed(ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2))))
    else $error("declination beyond a quarter turn");

endmodule
`default_nettype wire
